FILE: rtl/core/hms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hms_pkg
// Shared types and constants for the hue mean-shift mask block.
// ----------------------------------------------------------------------------
package hms_pkg;

    localparam int HMS_HUE_BINS   = 180;
    localparam int HMS_COUNT_BITS = 21;
    localparam int MIN_COUNT_W    = 21;

    // item kinds
    localparam logic [1:0] KIND_COUNT    = 2'd0;
    localparam logic [1:0] KIND_BUILD    = 2'd1;
    localparam logic [1:0] KIND_CLASSIFY = 2'd2;
    localparam logic [1:0] KIND_CLEAR    = 2'd3;

    // register indexes
    localparam logic [2:0] REG_TARGET_HUE    = 3'd0;
    localparam logic [2:0] REG_WINDOW_RADIUS = 3'd1;
    localparam logic [2:0] REG_ITER_LIMIT    = 3'd2;
    localparam logic [2:0] REG_MIN_BIN_COUNT = 3'd3;
    localparam logic [2:0] REG_SAT_FLOOR     = 3'd4;
    localparam logic [2:0] REG_BRI_FLOOR     = 3'd5;
    localparam logic [2:0] REG_BRI_CEILING   = 3'd6;
    localparam logic [2:0] REG_SEL_DISTANCE  = 3'd7;

    typedef struct packed {
        logic [7:0]             target_hue;
        logic [7:0]             window_radius;
        logic [7:0]             iteration_limit;
        logic [MIN_COUNT_W-1:0] min_bin_count;
        logic [7:0]             saturation_floor;
        logic [7:0]             brightness_floor;
        logic [7:0]             brightness_ceiling;
        logic [7:0]             selection_distance;
    } cfg_t;

    typedef struct packed {
        logic cap_item;
        logic cnt_rd;
        logic cnt_wr;
        logic cls_rd;
        logic cls_out;
        logic hist_clr;
        logic idx_clr;
        logic idx_inc;
        logic pr_rd;
        logic pr_chk;
        logic ms_init;
        logic scan_init;
        logic scan;
        logic div_start;
        logic div_step;
        logic ms_update;
        logic sel_wr;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       pix_ok;
        logic       idx_last;
        logic       nz_idx;
        logic       it_done;
        logic       scan_last;
        logic       n_zero;
        logic       div_last;
        logic       converged;
        logic       out_free;
    } status_t;

endpackage

FILE: rtl/core/hms_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hms_ctrl
// Sequencer: dispatches items and steps the build (prune, mean shift, select).
// ----------------------------------------------------------------------------
module hms_ctrl
    import hms_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t st,
    output cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_CNT_WR,
        S_CLS_OUT,
        S_PR_RD,
        S_PR_CHK,
        S_MS_START,
        S_MS_TEST,
        S_SCAN,
        S_CHK,
        S_DIV,
        S_UPD,
        S_SEL
    } state_t;

    state_t state_reg, state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.cap_item = 1'b1;
                    state_next   = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (st.kind)
                    KIND_COUNT:
                    begin
                        if (st.pix_ok)
                        begin
                            cmd.cnt_rd = 1'b1;
                            state_next = S_CNT_WR;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    KIND_BUILD:
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = S_PR_RD;
                    end
                    KIND_CLASSIFY:
                    begin
                        cmd.cls_rd = 1'b1;
                        state_next = S_CLS_OUT;
                    end
                    default:
                    begin
                        cmd.hist_clr = 1'b1;
                        state_next   = S_IDLE;
                    end
                endcase
            end
            S_CNT_WR:
            begin
                cmd.cnt_wr = 1'b1;
                state_next = S_IDLE;
            end
            S_CLS_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.cls_out = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_PR_RD:
            begin
                cmd.pr_rd  = 1'b1;
                state_next = S_PR_CHK;
            end
            S_PR_CHK:
            begin
                cmd.pr_chk = 1'b1;
                if (st.idx_last)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_MS_START;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_PR_RD;
                end
            end
            S_MS_START:
            begin
                if (st.nz_idx)
                begin
                    cmd.ms_init = 1'b1;
                    state_next  = S_MS_TEST;
                end
                else
                begin
                    state_next = S_SEL;
                end
            end
            S_MS_TEST:
            begin
                if (st.it_done)
                begin
                    state_next = S_SEL;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (st.scan_last)
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (st.n_zero)
                begin
                    state_next = S_SEL;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_last)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                if (st.converged)
                begin
                    state_next = S_SEL;
                end
                else
                begin
                    cmd.ms_update = 1'b1;
                    state_next    = S_MS_TEST;
                end
            end
            S_SEL:
            begin
                cmd.sel_wr = 1'b1;
                if (st.idx_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_MS_START;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/hms_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hms_datapath
// Histogram and selection memories, window scan, serial divider, result word.
// ----------------------------------------------------------------------------
module hms_datapath
    import hms_pkg::*;
#(
    parameter int HUE_BINS   = HMS_HUE_BINS,
    parameter int COUNT_BITS = HMS_COUNT_BITS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  cmd_t       cmd,
    output status_t    st,
    input  logic [1:0] kind,
    input  logic [7:0] hue,
    input  logic [7:0] saturation,
    input  logic [7:0] brightness,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       in_mask
);

    localparam int IDX_W = $clog2(HUE_BINS);
    localparam int SUM_W = $clog2((HUE_BINS - 1) * HUE_BINS + 1);
    localparam int N_W   = $clog2(HUE_BINS + 1);
    localparam int DC_W  = $clog2(SUM_W);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HUE_BINS - 1);

    // item
    logic [1:0] kind_reg;
    logic [7:0] hue_reg, sat_reg, bri_reg;

    // histogram: valid bit per bin, a bin is nonzero iff its valid bit is set
    logic [COUNT_BITS-1:0] cnt_mem [HUE_BINS];
    logic [COUNT_BITS-1:0] cnt_rd_reg;
    logic [HUE_BINS-1:0]   cv_reg;
    logic                  sel_mem [HUE_BINS];
    logic                  sel_rd_reg;
    logic [HUE_BINS-1:0]   sv_reg;

    logic [IDX_W-1:0] idx_reg, mean_reg, pos_reg, hi_reg;
    logic [SUM_W-1:0] sum_reg, quo_reg;
    logic [N_W-1:0]   n_reg, rem_reg;
    logic [7:0]       it_reg;
    logic [DC_W-1:0]  dcnt_reg;
    logic             out_valid_reg, in_mask_reg;

    logic             in_range, gates_ok;
    logic [IDX_W-1:0] hue_idx, cnt_addr;
    logic [8:0]       m9, r9, t9, lo9, hi9, dist9;
    logic [N_W:0]     shifted, trial;
    logic             div_ge;
    logic [COUNT_BITS-1:0] cur_cnt;
    logic             sel_bit;

    assign in_range = ({1'b0, hue_reg} < 9'(HUE_BINS));
    assign gates_ok = (sat_reg >= cfg.saturation_floor) &&
                      (bri_reg >= cfg.brightness_floor) &&
                      (bri_reg <= cfg.brightness_ceiling);
    assign hue_idx  = in_range ? hue_reg[IDX_W-1:0] : '0;
    assign cnt_addr = cmd.cnt_rd ? hue_idx : idx_reg;

    // window, clamped to the hue range
    always_comb
    begin
        m9  = 9'(mean_reg);
        r9  = {1'b0, cfg.window_radius};
        t9  = {1'b0, cfg.target_hue};
        lo9 = (m9 > r9) ? (m9 - r9) : 9'd0;
        hi9 = m9 + r9;
        if (hi9 > 9'(HUE_BINS - 1))
        begin
            hi9 = 9'(HUE_BINS - 1);
        end
        dist9 = (m9 >= t9) ? (m9 - t9) : (t9 - m9);
    end

    assign shifted = {rem_reg, quo_reg[SUM_W-1]};
    assign div_ge  = (shifted >= {1'b0, n_reg});
    assign trial   = shifted - {1'b0, n_reg};
    assign cur_cnt = cv_reg[hue_idx] ? cnt_rd_reg : '0;
    assign sel_bit = cv_reg[idx_reg] && (dist9 <= {1'b0, cfg.selection_distance});

    assign st.kind      = kind_reg;
    assign st.pix_ok    = in_range && gates_ok;
    assign st.idx_last  = (idx_reg == IDX_LAST);
    assign st.nz_idx    = cv_reg[idx_reg];
    assign st.it_done   = (it_reg == cfg.iteration_limit);
    assign st.scan_last = (pos_reg == hi_reg);
    assign st.n_zero    = (n_reg == '0);
    assign st.div_last  = (dcnt_reg == DC_W'(SUM_W - 1));
    assign st.converged = (quo_reg == SUM_W'(mean_reg));
    assign st.out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign in_mask   = in_mask_reg;

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.cnt_rd || cmd.pr_rd)
        begin
            cnt_rd_reg <= cnt_mem[cnt_addr];
        end
        if (cmd.cnt_wr && (cur_cnt != '1))
        begin
            cnt_mem[hue_idx] <= cur_cnt + COUNT_BITS'(1);
        end
        if (cmd.cls_rd)
        begin
            sel_rd_reg <= sel_mem[hue_idx];
        end
        if (cmd.sel_wr)
        begin
            sel_mem[idx_reg] <= sel_bit;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg        <= '0;
            sv_reg        <= '0;
            out_valid_reg <= 1'b0;
            in_mask_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.hist_clr)
            begin
                cv_reg <= '0;
            end
            else if (cmd.cnt_wr)
            begin
                cv_reg[hue_idx] <= 1'b1;
            end
            else if (cmd.pr_chk && cv_reg[idx_reg] &&
                     (32'(cnt_rd_reg) < 32'(cfg.min_bin_count)))
            begin
                cv_reg[idx_reg] <= 1'b0;
            end
            if (cmd.sel_wr)
            begin
                sv_reg[idx_reg] <= 1'b1;
            end
            if (cmd.cls_out)
            begin
                out_valid_reg <= 1'b1;
                in_mask_reg   <= st.pix_ok && sv_reg[hue_idx] && sel_rd_reg;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.cap_item)
        begin
            kind_reg <= kind;
            hue_reg  <= hue;
            sat_reg  <= saturation;
            bri_reg  <= brightness;
        end
        if (cmd.idx_clr)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
        if (cmd.ms_init)
        begin
            mean_reg <= idx_reg;
            it_reg   <= '0;
        end
        else if (cmd.ms_update)
        begin
            mean_reg <= quo_reg[IDX_W-1:0];
            it_reg   <= it_reg + 8'd1;
        end
        if (cmd.scan_init)
        begin
            pos_reg <= lo9[IDX_W-1:0];
            hi_reg  <= hi9[IDX_W-1:0];
            sum_reg <= '0;
            n_reg   <= '0;
        end
        else if (cmd.scan)
        begin
            pos_reg <= pos_reg + IDX_W'(1);
            if (cv_reg[pos_reg])
            begin
                sum_reg <= sum_reg + SUM_W'(pos_reg);
                n_reg   <= n_reg + N_W'(1);
            end
        end
        // restoring divider, one quotient bit a cycle
        if (cmd.div_start)
        begin
            quo_reg  <= sum_reg;
            rem_reg  <= '0;
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= div_ge ? trial[N_W-1:0] : shifted[N_W-1:0];
            quo_reg  <= {quo_reg[SUM_W-2:0], div_ge};
            dcnt_reg <= dcnt_reg + DC_W'(1);
        end
    end

endmodule

FILE: rtl/core/hue_mean_shift_mask.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hue_mean_shift_mask
// Hue histogram with 1-D mean-shift clustering and a per-pixel hue mask.
// ----------------------------------------------------------------------------
//  channel   direction  signals
//  in        sink       in_valid, in_stall, kind, hue, saturation, brightness
//  out       source     out_valid, out_stall, in_mask
//  cfg       APB slave  psel, penable, pwrite, paddr, pwdata, prdata, pready
//
//  Classify words wait in their last state while the output is stalled.
//  Build: prunes every bin through the histogram read port, then for each
//  nonzero bin runs mean-shift steps, each a window scan and a serial
//  divide, and writes the bin's selection.
//  Reset clears the histogram and selections at once through valid bits.
//  in_stall is high whenever a word is in progress.
// ----------------------------------------------------------------------------
module hue_mean_shift_mask
    import hms_pkg::*;
#(
    parameter int HUE_BINS   = HMS_HUE_BINS,
    parameter int COUNT_BITS = HMS_COUNT_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  hue,
    input  logic [7:0]  saturation,
    input  logic [7:0]  brightness,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        in_mask,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t    cfg_reg;
    cmd_t    cmd;
    status_t st;
    logic    wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_hue         <= 8'd60;
            cfg_reg.window_radius      <= 8'd10;
            cfg_reg.iteration_limit    <= 8'd10;
            cfg_reg.min_bin_count      <= MIN_COUNT_W'(100);
            cfg_reg.saturation_floor   <= 8'd0;
            cfg_reg.brightness_floor   <= 8'd0;
            cfg_reg.brightness_ceiling <= 8'd255;
            cfg_reg.selection_distance <= 8'd10;
        end
        else if (wr_en)
        begin
            case (paddr[4:2])
                REG_TARGET_HUE:    cfg_reg.target_hue         <= pwdata[7:0];
                REG_WINDOW_RADIUS: cfg_reg.window_radius      <= pwdata[7:0];
                REG_ITER_LIMIT:    cfg_reg.iteration_limit    <= pwdata[7:0];
                REG_MIN_BIN_COUNT: cfg_reg.min_bin_count      <= pwdata[MIN_COUNT_W-1:0];
                REG_SAT_FLOOR:     cfg_reg.saturation_floor   <= pwdata[7:0];
                REG_BRI_FLOOR:     cfg_reg.brightness_floor   <= pwdata[7:0];
                REG_BRI_CEILING:   cfg_reg.brightness_ceiling <= pwdata[7:0];
                REG_SEL_DISTANCE:  cfg_reg.selection_distance <= pwdata[7:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_TARGET_HUE:    prdata = 32'(cfg_reg.target_hue);
            REG_WINDOW_RADIUS: prdata = 32'(cfg_reg.window_radius);
            REG_ITER_LIMIT:    prdata = 32'(cfg_reg.iteration_limit);
            REG_MIN_BIN_COUNT: prdata = 32'(cfg_reg.min_bin_count);
            REG_SAT_FLOOR:     prdata = 32'(cfg_reg.saturation_floor);
            REG_BRI_FLOOR:     prdata = 32'(cfg_reg.brightness_floor);
            REG_BRI_CEILING:   prdata = 32'(cfg_reg.brightness_ceiling);
            REG_SEL_DISTANCE:  prdata = 32'(cfg_reg.selection_distance);
            default:           prdata = '0;
        endcase
    end

    hms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    hms_datapath #(
        .HUE_BINS   (HUE_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cmd        (cmd),
        .st         (st),
        .kind       (kind),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .in_mask    (in_mask)
    );

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for hue_mean_shift_mask. A short stimulus table, then
// phases of clear / count / build / classify words with random content,
// each under its own register settings and idle pattern. An in-bench
// histogram and mean-shift model predicts each in_mask word the table does
// not give, and results are checked in order as they leave the block.
// ----------------------------------------------------------------------------
module testbench;
    import hms_pkg::*;

    localparam int BINS      = HMS_HUE_BINS;
    localparam int CNT_TOP   = (1 << HMS_COUNT_BITS) - 1;
    localparam int CYC_LIMIT = 8000000;
    localparam int N_PHASES  = 10;

    typedef struct packed {
        logic [1:0] k;
        logic [7:0] h;
        logic [7:0] s;
        logic [7:0] b;
        bit         known;
        bit         val;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  kind = KIND_COUNT;
    logic [7:0]  hue = 8'd0;
    logic [7:0]  saturation = 8'd0;
    logic [7:0]  brightness = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        in_mask;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = 5'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // model state
    cfg_t                      cfg_now;
    logic [HMS_COUNT_BITS-1:0] hist_cnt [BINS];
    bit                        hue_sel [BINS];
    bit                        mask_q [$];

    int  snd_idle_pct = 0;
    int  rcv_stall_pct = 0;
    bit  hold_req = 1'b0;
    int  hold_left = 0;
    int  cycles = 0;
    int  errors = 0;
    int  words_sent = 0;
    int  masks_seen = 0;
    int  masks_set = 0;
    int  builds = 0;
    logic [7:0] hue_pool [$];

    row_t dir_tab [20] = '{
        '{KIND_CLASSIFY, 8'd60,  8'd255, 8'd255, 1'b1, 1'b0},
        '{KIND_CLASSIFY, 8'd180, 8'd255, 8'd255, 1'b1, 1'b0},
        '{KIND_CLASSIFY, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0},
        '{KIND_COUNT,    8'd60,  8'd255, 8'd255, 1'b0, 1'b0},
        '{KIND_COUNT,    8'd60,  8'd0,   8'd0,   1'b0, 1'b0},
        '{KIND_COUNT,    8'd0,   8'd128, 8'd1,   1'b0, 1'b0},
        '{KIND_COUNT,    8'd179, 8'd1,   8'd254, 1'b0, 1'b0},
        '{KIND_COUNT,    8'd180, 8'd255, 8'd255, 1'b0, 1'b0},
        '{KIND_COUNT,    8'd255, 8'd0,   8'd255, 1'b0, 1'b0},
        '{KIND_COUNT,    8'd65,  8'd85,  8'd170, 1'b0, 1'b0},
        '{KIND_BUILD,    8'd0,   8'd0,   8'd0,   1'b0, 1'b0},
        '{KIND_CLASSIFY, 8'd60,  8'd255, 8'd255, 1'b0, 1'b0},
        '{KIND_CLASSIFY, 8'd0,   8'd0,   8'd0,   1'b0, 1'b0},
        '{KIND_CLASSIFY, 8'd179, 8'd170, 8'd85,  1'b0, 1'b0},
        '{KIND_CLASSIFY, 8'd65,  8'd1,   8'd1,   1'b0, 1'b0},
        '{KIND_CLASSIFY, 8'd180, 8'd255, 8'd255, 1'b1, 1'b0},
        '{KIND_CLEAR,    8'd0,   8'd0,   8'd0,   1'b0, 1'b0},
        '{KIND_CLASSIFY, 8'd60,  8'd255, 8'd255, 1'b0, 1'b0},
        '{KIND_BUILD,    8'd0,   8'd0,   8'd0,   1'b0, 1'b0},
        '{KIND_CLASSIFY, 8'd60,  8'd255, 8'd255, 1'b1, 1'b0}
    };

    hue_mean_shift_mask u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .in_mask    (in_mask),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("hue_mean_shift_mask: mismatch");
            $finish;
        end
    end

    // ---- model ----------------------------------------------------------
    function automatic bit pix_pass(logic [7:0] s, logic [7:0] b);
        return s >= cfg_now.saturation_floor && b >= cfg_now.brightness_floor &&
               b <= cfg_now.brightness_ceiling;
    endfunction

    function automatic int converge(int start);
        int mean;
        int lo;
        int hi;
        int sum;
        int n;
        int nxt;
        mean = start;
        for (int it = 0; it < int'(cfg_now.iteration_limit); it++)
        begin
            lo = (mean > int'(cfg_now.window_radius)) ? mean - cfg_now.window_radius : 0;
            hi = mean + cfg_now.window_radius;
            if (hi > BINS - 1)
                hi = BINS - 1;
            sum = 0;
            n = 0;
            for (int p = lo; p <= hi; p++)
            begin
                if (hist_cnt[p] != 0)
                begin
                    sum += p;
                    n++;
                end
            end
            if (n == 0)
                break;
            nxt = sum / n;
            if (nxt == mean)
                break;
            mean = nxt;
        end
        return mean;
    endfunction

    task automatic model_word(logic [1:0] k, logic [7:0] h, logic [7:0] s, logic [7:0] b,
                              bit known, bit val);
        int m;
        int d;
        case (k)
            KIND_COUNT:
            begin
                if (h < BINS && pix_pass(s, b) && hist_cnt[h] < CNT_TOP)
                    hist_cnt[h] = hist_cnt[h] + 1'b1;
            end
            KIND_BUILD:
            begin
                builds++;
                for (int i = 0; i < BINS; i++)
                    if (hist_cnt[i] < cfg_now.min_bin_count)
                        hist_cnt[i] = '0;
                for (int i = 0; i < BINS; i++)
                begin
                    hue_sel[i] = 1'b0;
                    if (hist_cnt[i] != 0)
                    begin
                        m = converge(i);
                        d = (m >= int'(cfg_now.target_hue)) ? m - cfg_now.target_hue
                                                            : cfg_now.target_hue - m;
                        hue_sel[i] = (d <= int'(cfg_now.selection_distance));
                    end
                end
            end
            KIND_CLASSIFY:
            begin
                if (known)
                    mask_q.insert(mask_q.size(), val);
                else
                    mask_q.insert(mask_q.size(),
                                  h < BINS && pix_pass(s, b) && hue_sel[h]);
            end
            default:
            begin
                for (int i = 0; i < BINS; i++)
                    hist_cnt[i] = '0;
            end
        endcase
    endtask

    // ---- drivers --------------------------------------------------------
    task automatic send_word(logic [1:0] k, logic [7:0] h, logic [7:0] s, logic [7:0] b,
                             bit known = 1'b0, bit val = 1'b0);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        hue        <= h;
        saturation <= s;
        brightness <= b;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
        model_word(k, h, s, b, known, val);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_cfg(cfg_t c);
        reg_write(REG_TARGET_HUE,    32'(c.target_hue));
        reg_write(REG_WINDOW_RADIUS, 32'(c.window_radius));
        reg_write(REG_ITER_LIMIT,    32'(c.iteration_limit));
        reg_write(REG_MIN_BIN_COUNT, 32'(c.min_bin_count));
        reg_write(REG_SAT_FLOOR,     32'(c.saturation_floor));
        reg_write(REG_BRI_FLOOR,     32'(c.brightness_floor));
        reg_write(REG_BRI_CEILING,   32'(c.brightness_ceiling));
        reg_write(REG_SEL_DISTANCE,  32'(c.selection_distance));
        cfg_now = c;
    endtask

    // wait out results, then any word still in flight (build may be long)
    task automatic drain();
        in_valid <= 1'b0;
        while (mask_q.size() != 0)
            @(posedge clk);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_hue(int center);
        int h;
        if ($urandom_range(99) < 12)
            return 8'($urandom_range(255));
        h = center + $urandom_range(12) - 6;
        if (h < 0)
            h = 0;
        return 8'(h);
    endfunction

    // ---- receiver -------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_req && hold_left == 0)
        begin
            hold_left <= 400;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= (hold_left > 1) ? 1'b1 : 1'b0;
        end
        else
            out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            masks_seen++;
            if (in_mask)
                masks_set++;
            if (mask_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected in_mask word %b at cycle %0d", in_mask, cycles);
            end
            else if (in_mask !== mask_q[0])
            begin
                errors++;
                if (errors <= 10)
                    $display("in_mask: expected %b, got %b at cycle %0d",
                             mask_q[0], in_mask, cycles);
                void'(mask_q.pop_front());
            end
            else
                void'(mask_q.pop_front());
        end
    end

    // ---- main sequence --------------------------------------------------
    initial
    begin
        cfg_t c;
        int   center;
        int   n_cls;
        for (int i = 0; i < BINS; i++)
        begin
            hist_cnt[i] = '0;
            hue_sel[i]  = 1'b0;
        end
        cfg_now = '{target_hue: 8'd60, window_radius: 8'd10, iteration_limit: 8'd10,
                    min_bin_count: 21'd100, saturation_floor: 8'd0, brightness_floor: 8'd0,
                    brightness_ceiling: 8'd255, selection_distance: 8'd10};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        c = cfg_now;
        c.min_bin_count = 21'd1;
        load_cfg(c);
        foreach (dir_tab[i])
            send_word(dir_tab[i].k, dir_tab[i].h, dir_tab[i].s, dir_tab[i].b,
                      dir_tab[i].known, dir_tab[i].val);
        drain();

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            case (ph)
                1:  c = '{target_hue: 8'd179, window_radius: 8'd179, iteration_limit: 8'd255,
                          min_bin_count: 21'd1048576, saturation_floor: 8'd255,
                          brightness_floor: 8'd255, brightness_ceiling: 8'd255,
                          selection_distance: 8'd179};
                2:  c = '{target_hue: 8'd0, window_radius: 8'd0, iteration_limit: 8'd0,
                          min_bin_count: 21'd0, saturation_floor: 8'd0,
                          brightness_floor: 8'd0, brightness_ceiling: 8'd0,
                          selection_distance: 8'd0};
                3:  c = '{target_hue: 8'($urandom_range(179)), window_radius: 8'd179,
                          iteration_limit: 8'd255, min_bin_count: 21'd1,
                          saturation_floor: 8'd0, brightness_floor: 8'd0,
                          brightness_ceiling: 8'd255, selection_distance: 8'd20};
                default:
                    c = '{target_hue: 8'($urandom_range(179)),
                          window_radius: 8'($urandom_range(15)),
                          iteration_limit: 8'($urandom_range(12)),
                          min_bin_count: 21'($urandom_range(3)),
                          saturation_floor: 8'($urandom_range(90)),
                          brightness_floor: 8'($urandom_range(70)),
                          brightness_ceiling: 8'($urandom_range(255, 160)),
                          selection_distance: 8'($urandom_range(30))};
            endcase
            load_cfg(c);
            case (ph % 4)
                0:       begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1:       begin snd_idle_pct = 49; rcv_stall_pct = 0;  end
                2:       begin snd_idle_pct = 0;  rcv_stall_pct = 49; end
                default: begin snd_idle_pct = 15; rcv_stall_pct = 15; end
            endcase

            hue_pool.delete();
            center = $urandom_range(179);
            // hues cluster around a random center; the target is drawn independently
            send_word(KIND_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
            for (int i = 0; i < 25; i++)
            begin
                if (i == 12)
                    center = $urandom_range(179);
                hue_pool.insert(hue_pool.size(), pick_hue(center));
                send_word(KIND_COUNT, hue_pool[$], 8'($urandom), 8'($urandom));
            end
            send_word(KIND_BUILD, 8'($urandom), 8'($urandom), 8'($urandom));
            if (ph == 5)
                hold_req <= 1'b1;
            n_cls = (ph == 5) ? 30 : 15;
            for (int i = 0; i < n_cls; i++)
            begin
                if (ph == 5 && i == 1)
                    hold_req <= 1'b0;
                send_word(KIND_CLASSIFY,
                          ($urandom_range(3) == 0) ? 8'($urandom)
                                                   : hue_pool[$urandom_range(24)],
                          8'($urandom), 8'($urandom));
            end
            // stray words: any kind, any field values
            for (int i = 0; i < 5; i++)
                send_word(2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            send_word(KIND_CLASSIFY, hue_pool[0], 8'hff, 8'($urandom));
            drain();
        end

        if (mask_q.size() != 0)
        begin
            errors++;
            $display("%0d in_mask words never arrived", mask_q.size());
        end
        $display("covered %0d words in %0d setting phases, %0d builds, %0d cycles",
                 words_sent, N_PHASES + 1, builds, cycles);
        $display("checked %0d mask words (%0d set), %0d errors",
                 masks_seen, masks_set, errors);
        if (errors == 0)
            $display("hue_mean_shift_mask: match");
        else
            $display("hue_mean_shift_mask: mismatch");
        $finish;
    end

endmodule
